@@ hdl/tws_pkg.sv @@
// Shared types and constants for the time-window temperature statistics block.
// No dependencies.
package tws_pkg;
    localparam int DEPTH_DEF     = 64;
    localparam int TEMP_BITS_DEF = 16;
    localparam int WIN_BITS      = 12;
    localparam int TIME_BITS     = 32;
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 12'd10;
    localparam int FAHR_OFFSET   = 4096;

    localparam logic [0:0] CFG_WINDOW = 1'b0;
    localparam logic [0:0] CFG_FAHR   = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture new input transaction
        logic exp_rd;    // read head entry for expiry check
        logic exp_drop;  // drop head entry (expired)
        logic ovf_drop;  // drop head entry (store full)
        logic push;      // write new sample
        logic scan_init; // start min/max scan at head
        logic scan_rd;   // issue scan read
        logic div_start; // start average division
        logic div_step;  // one restoring division step
        logic conv_step; // next Fahrenheit conversion step
        logic fin;       // build result
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic expired;   // head entry older than window (valid after exp_rd)
        logic is_tick;
        logic scan_last; // last entry issued
        logic div_done;
        logic conv_done;
    } t_sts;
endpackage

@@ hdl/tws_if.sv @@
// Valid/ready stream and configuration channel interfaces.
// Depends on tws_pkg.
interface tws_in_if #(parameter int TEMP_BITS = tws_pkg::TEMP_BITS_DEF);
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [31:0]               time_now;
    logic signed [TEMP_BITS-1:0] sample_temp;
    modport source(output valid, kind, time_now, sample_temp, input ready);
    modport sink(input valid, kind, time_now, sample_temp, output ready);
endinterface

interface tws_out_if #(parameter int TEMP_BITS = tws_pkg::TEMP_BITS_DEF,
                       parameter int CNT_BITS = 7);
    logic                        valid;
    logic                        ready;
    logic signed [TEMP_BITS:0]   current_temp;
    logic signed [TEMP_BITS:0]   average_temp;
    logic signed [TEMP_BITS:0]   max_temp;
    logic signed [TEMP_BITS:0]   min_temp;
    logic [CNT_BITS-1:0]         sample_count;
    logic                        overflow;
    modport source(output valid, current_temp, average_temp, max_temp, min_temp,
                   sample_count, overflow, input ready);
    modport sink(input valid, current_temp, average_temp, max_temp, min_temp,
                 sample_count, overflow, output ready);
endinterface

interface tws_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [11:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/tws_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hdl/tws_ctrl.sv @@
// Sequencing state machine: expiry walk, push, min/max scan, divide, convert.
// Depends on tws_pkg.
module tws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tws_pkg::t_sts  i_sts,
    output tws_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXRD  = 4'd1;
    localparam logic [3:0] S_EXWT  = 4'd2;
    localparam logic [3:0] S_EXCHK = 4'd3;
    localparam logic [3:0] S_PUSH  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_DRN2  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_CONV  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state, n_state;
    logic       in_hs;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_hs       = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_hs) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXRD;
                end
            end
            S_EXRD: begin
                if (i_sts.empty) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.exp_rd = 1'b1;
                    n_state      = S_EXWT;
                end
            end
            // keep the head address so the check sees the head entry
            S_EXWT: begin
                o_cmd.exp_rd = 1'b1;
                n_state      = S_EXCHK;
            end
            S_EXCHK: begin
                if (i_sts.expired) begin
                    o_cmd.exp_drop = 1'b1;
                    n_state        = S_EXRD;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_sts.is_tick) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.ovf_drop = i_sts.full;
                end
                n_state = S_SCAN;
                o_cmd.scan_init = 1'b1;
            end
            S_SCAN: begin
                if (i_sts.empty) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_DRN2;
            end
            S_DRN2: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CONV;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.conv_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ hdl/tws_dp.sv @@
// Datapath: circular sample store, running sum, scan min/max, serial divider,
// Fahrenheit conversion. Depends on tws_pkg and tws_ram.
module tws_dp #(
    parameter int DEPTH     = tws_pkg::DEPTH_DEF,
    parameter int TEMP_BITS = tws_pkg::TEMP_BITS_DEF,
    parameter int PTR_BITS  = $clog2(DEPTH),
    parameter int CNT_BITS  = $clog2(DEPTH + 1),
    parameter int SUM_BITS  = TEMP_BITS + CNT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tws_pkg::t_cmd               i_cmd,
    output tws_pkg::t_sts               o_sts,
    input  logic                        i_kind,
    input  logic [31:0]                 i_time_now,
    input  logic signed [TEMP_BITS-1:0] i_sample_temp,
    input  logic [11:0]                 i_window,
    input  logic                        i_fahr,
    output logic signed [TEMP_BITS:0]   o_current_temp,
    output logic signed [TEMP_BITS:0]   o_average_temp,
    output logic signed [TEMP_BITS:0]   o_max_temp,
    output logic signed [TEMP_BITS:0]   o_min_temp,
    output logic [CNT_BITS-1:0]         o_sample_count,
    output logic                        o_overflow
);
    localparam int W = 32 + TEMP_BITS;
    localparam int OB = TEMP_BITS + 1;
    localparam int DIV_STEPS = SUM_BITS;

    // input capture
    logic                        r_kind;
    logic [31:0]                 r_now;
    logic signed [TEMP_BITS-1:0] r_temp;

    // window control state
    logic [PTR_BITS-1:0]         r_head, r_tail, r_scan;
    logic [CNT_BITS-1:0]         r_count, r_scan_left;
    logic signed [SUM_BITS-1:0]  r_sum;
    logic signed [TEMP_BITS-1:0] r_latest;
    logic                        r_ovf;

    // head entry temperature, held from the last expiry check
    logic                        r_exv;
    logic signed [TEMP_BITS-1:0] r_head_temp;

    // memory ports
    logic                        we;
    logic [PTR_BITS-1:0]         raddr;
    logic [W-1:0]                rdata;

    // scan pipeline: read issued, data valid next cycle
    logic                        r_rdv;
    logic                        r_first;
    logic signed [TEMP_BITS-1:0] r_max, r_min;

    // divider
    logic [SUM_BITS-1:0]         r_quo, r_rem;
    logic [$clog2(DIV_STEPS+1)-1:0] r_dcnt;
    logic                        r_neg;

    // conversion (four values, one per step)
    logic [2:0]                  r_cidx;
    logic signed [OB-1:0]        r_cv [4];

    assign we    = i_cmd.push;
    assign raddr = i_cmd.exp_rd ? r_head : r_scan;

    tws_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_tail),
        .i_wdata({r_now, r_temp}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [31:0] age;
    logic signed [TEMP_BITS-1:0] rd_temp;
    assign age     = r_now - rdata[W-1:TEMP_BITS];
    assign rd_temp = rdata[TEMP_BITS-1:0];

    // status
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CNT_BITS'(DEPTH));
    assign o_sts.expired   = (age > {20'd0, i_window});
    assign o_sts.is_tick   = (r_kind == tws_pkg::KIND_TICK);
    assign o_sts.scan_last = (r_scan_left == CNT_BITS'(1));
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.conv_done = (r_cidx == 3'd4);

    // divider step: restoring, magnitude
    logic [SUM_BITS-1:0] rem_sh, sub;
    logic                ge;
    assign rem_sh = {r_rem[SUM_BITS-2:0], r_quo[SUM_BITS-1]};
    assign ge     = (rem_sh >= SUM_BITS'(r_count));
    assign sub    = rem_sh - SUM_BITS'(r_count);

    // Fahrenheit of one value: floor(v*9/5)+4096 via reciprocal multiply
    logic signed [OB-1:0] cin, cout;
    logic signed [OB+4:0] p9;
    logic [OB+4:0]        pb;
    logic [OB+4:0]        q;
    logic [2*(OB+5):0]    prod;
    localparam int RECIP_SH = OB + 5 + 3;
    localparam logic [OB+5:0] RECIP = (OB+6)'(((64'd1 << RECIP_SH) + 4) / 5);
    always_comb begin
        unique case (r_cidx[1:0])
            2'd0:    cin = r_cv[0];
            2'd1:    cin = r_cv[1];
            2'd2:    cin = r_cv[2];
            default: cin = r_cv[3];
        endcase
        p9 = (OB+5)'(cin) * (OB+5)'(9);
        // bias so floor of positive value: p9 + 5*2^(OB+2) is >= 0
        pb   = (OB+5)'(p9) + (OB+5)'(64'd5 << (OB + 2));
        prod = (2*(OB+5)+1)'(pb) * (2*(OB+5)+1)'(RECIP);
        q    = (OB+5)'(prod >> RECIP_SH);
        cout = OB'(q - (OB+5)'(64'd1 << (OB + 2)) + (OB+5)'(tws_pkg::FAHR_OFFSET));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_latest <= '0;
            r_rdv    <= 1'b0;
            r_exv    <= 1'b0;
            r_dcnt   <= '0;
            r_cidx   <= 3'd4;
        end else begin
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_now  <= i_time_now;
                r_temp <= i_sample_temp;
                r_ovf  <= 1'b0;
            end
            // head temperature follows each expiry read
            r_exv <= i_cmd.exp_rd;
            if (r_exv) begin
                r_head_temp <= rd_temp;
            end
            // expiry drop uses the head data just read
            if (i_cmd.exp_drop) begin
                r_sum   <= r_sum - SUM_BITS'(rd_temp);
                r_head  <= (r_head == PTR_BITS'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.push) begin
                r_tail   <= (r_tail == PTR_BITS'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_latest <= r_temp;
                if (i_cmd.ovf_drop) begin
                    // full store: head == tail, overwrite oldest
                    r_head <= (r_head == PTR_BITS'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_ovf  <= 1'b1;
                    r_sum  <= r_sum + SUM_BITS'(r_temp) - SUM_BITS'(r_head_temp);
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SUM_BITS'(r_temp);
                end
            end
            // scan
            if (i_cmd.scan_init) begin
                r_scan      <= i_cmd.ovf_drop ?
                               ((r_head == PTR_BITS'(DEPTH - 1)) ? '0 : r_head + 1'b1) : r_head;
                r_scan_left <= (i_cmd.push && !i_cmd.ovf_drop) ? r_count + 1'b1 : r_count;
                r_first     <= 1'b1;
            end
            if (i_cmd.scan_rd) begin
                r_scan      <= (r_scan == PTR_BITS'(DEPTH - 1)) ? '0 : r_scan + 1'b1;
                r_scan_left <= r_scan_left - 1'b1;
            end
            r_rdv <= i_cmd.scan_rd;
            if (r_rdv) begin
                r_first <= 1'b0;
                if (r_first || rd_temp > r_max) r_max <= rd_temp;
                if (r_first || rd_temp < r_min) r_min <= rd_temp;
            end
            // divider
            if (i_cmd.div_start) begin
                r_neg  <= r_sum[SUM_BITS-1];
                r_quo  <= r_sum[SUM_BITS-1] ? SUM_BITS'(-r_sum) : SUM_BITS'(r_sum);
                r_rem  <= '0;
                r_dcnt <= (r_count == '0) ? '0 : ($bits(r_dcnt))'(DIV_STEPS);
            end
            if (i_cmd.div_step) begin
                r_rem  <= ge ? sub : rem_sh;
                r_quo  <= {r_quo[SUM_BITS-2:0], ge};
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == ($bits(r_dcnt))'(1)) begin
                    r_cidx <= 3'd0;
                end
            end
            if (i_cmd.div_start && r_count == '0) begin
                r_cidx <= 3'd0;
            end
            // load conversion inputs once division completes
            if (i_cmd.div_step && r_dcnt == ($bits(r_dcnt))'(1)) begin
                r_cv[0] <= OB'(r_latest);
                r_cv[1] <= r_neg ? -OB'({r_quo[SUM_BITS-2:0], ge})
                                 :  OB'({r_quo[SUM_BITS-2:0], ge});
                r_cv[2] <= OB'(r_max);
                r_cv[3] <= OB'(r_min);
            end
            if (i_cmd.div_start && r_count == '0) begin
                r_cv[0] <= OB'(r_latest);
                r_cv[1] <= '0;
                r_cv[2] <= '0;
                r_cv[3] <= '0;
            end
            if (i_cmd.conv_step) begin
                if (i_fahr && !(o_sts.empty && r_cidx != 3'd0)) begin
                    r_cv[r_cidx[1:0]] <= cout;
                end
                r_cidx <= r_cidx + 1'b1;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_current_temp <= r_cv[0];
            o_average_temp <= r_cv[1];
            o_max_temp     <= r_cv[2];
            o_min_temp     <= r_cv[3];
            o_sample_count <= r_count;
            o_overflow     <= r_ovf;
        end
    end
endmodule

@@ hdl/time_window_temperature_stats_top.sv @@
// Top level of the time-window temperature statistics block.
// Depends on tws_pkg, tws_if, tws_ram, tws_ctrl, tws_dp.
//
// Usage:
//   in  channel: kind, time_now, sample_temp. kind 0 stores a sample, 1 is a tick.
//   out channel: one result transaction per input transaction: latest reading,
//                window average, maximum, minimum, count, overflow flag.
//   cfg channel: index 0 window_seconds, index 1 use_fahrenheit; always ready;
//                the user writes it only while idle, which the block does not enforce.
// Sequence: one item at a time. An accepted item goes through an expiry walk
//   that checks head entries (E expired entries plus the one that stops the
//   walk), a min/max scan of the N live entries, a one-bit per cycle divider for
//   the average and four Fahrenheit conversion steps before its result is valid.
//   The walk checks no entry on an empty store; the scan and the divider are
//   skipped when the window ends empty.
// Reset (i_rst_n low, synchronous) empties the window, clears the sum and the
//   latest reading and restores the register defaults; the store needs no
//   clearing pass.
// A stalled receiver holds the result; no new input is taken until it is taken.
module time_window_temperature_stats_top #(
    parameter int DEPTH     = tws_pkg::DEPTH_DEF,
    parameter int TEMP_BITS = tws_pkg::TEMP_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tws_in_if.sink    in_ch,
    tws_out_if.source out_ch,
    tws_cfg_if.sink   cfg_ch
);
    tws_pkg::t_cmd cmd;
    tws_pkg::t_sts sts;
    logic [11:0]   r_window;
    logic          r_fahr;

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tws_pkg::WINDOW_RESET;
            r_fahr   <= 1'b0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                tws_pkg::CFG_WINDOW: r_window <= cfg_ch.data;
                tws_pkg::CFG_FAHR:   r_fahr   <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    tws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tws_dp #(.DEPTH(DEPTH), .TEMP_BITS(TEMP_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (in_ch.kind),
        .i_time_now    (in_ch.time_now),
        .i_sample_temp (in_ch.sample_temp),
        .i_window      (r_window),
        .i_fahr        (r_fahr),
        .o_current_temp(out_ch.current_temp),
        .o_average_temp(out_ch.average_temp),
        .o_max_temp    (out_ch.max_temp),
        .o_min_temp    (out_ch.min_temp),
        .o_sample_count(out_ch.sample_count),
        .o_overflow    (out_ch.overflow)
    );
endmodule
